[rtl/stcag_pkg.sv]
// ----------------------------------------------------------------------------
// stcag_pkg
// Types and constants shared by the strided address generator modules.
// ----------------------------------------------------------------------------
package stcag_pkg;

  localparam int unsigned NDIM       = 3;
  localparam int unsigned IDX_W      = 48;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned STRIDE_W   = 32;
  localparam int unsigned EB_W       = 4;
  localparam int unsigned PROD_W     = 2 * SIZE_W;
  localparam int unsigned Q2_W       = 32;
  localparam int unsigned MUL_W      = SIZE_W + STRIDE_W;
  localparam int unsigned SRC_W      = 52;
  localparam int unsigned SRCB_W     = 55;
  localparam int unsigned DSTB_W     = 51;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM0_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIM1_STRIDE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIM2_STRIDE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES  = 3'd7;

  typedef struct packed {
    logic [NDIM-1:0][SIZE_W-1:0]   size;
    logic [NDIM-1:0][STRIDE_W-1:0] stride;
    logic [STRIDE_W-1:0]           base;
    logic [EB_W-1:0]               eb;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DSTB_W-1:0] dst_byte;
    logic              invalid;
  } item_t;

endpackage

[rtl/stcag_front.sv]
// ----------------------------------------------------------------------------
// stcag_front
// Takes items, checks the index against the size product, works out the
// destination byte offset and hands classified items to the queue.
// ----------------------------------------------------------------------------
module stcag_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stcag_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stcag_pkg::IDX_W-1:0]   dest_index_i,
  output logic                          push_o,
  output stcag_pkg::item_t              item_o,
  input  logic                          full_i
);

  logic                            va_q, vb_q;
  logic                            en_a, en_b;
  logic [stcag_pkg::IDX_W-1:0]     idx_a_q, idx_b_q;
  logic [stcag_pkg::PROD_W-1:0]    p01_q;
  logic [stcag_pkg::IDX_W-1:0]     prod_q;
  logic [stcag_pkg::DSTB_W-1:0]    dstb_q;
  logic [stcag_pkg::IDX_W+stcag_pkg::EB_W-1:0] dstb_full;

  assign en_b       = !vb_q || !full_i;
  assign en_a       = !va_q || en_b;
  assign in_stall_o = va_q && !en_a;
  assign push_o     = vb_q && !full_i;

  assign dstb_full = idx_a_q * cfg_i.eb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      idx_a_q <= dest_index_i;
      p01_q   <= cfg_i.size[0] * cfg_i.size[1];
    end
    if (en_b && va_q) begin
      idx_b_q <= idx_a_q;
      prod_q  <= p01_q * cfg_i.size[2];
      dstb_q  <= dstb_full[stcag_pkg::DSTB_W-1:0];
    end
  end

  assign item_o.idx      = idx_b_q;
  assign item_o.dst_byte = dstb_q;
  assign item_o.invalid  = !(idx_b_q < prod_q);

endmodule

[rtl/stcag_queue.sv]
// ----------------------------------------------------------------------------
// stcag_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module stcag_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stcag_pkg::item_t item_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output stcag_pkg::item_t item_o
);

  stcag_pkg::item_t mem_q [0:1];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

[rtl/stcag_back.sv]
// ----------------------------------------------------------------------------
// stcag_back
// Pipelined mixed-radix split (two restoring dividers, one bit per stage),
// stride multiplies, offset sum and byte scaling, ending in the output reg.
// ----------------------------------------------------------------------------
module stcag_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stcag_pkg::cfg_t                cfg_i,
  input  logic                           q_valid_i,
  input  stcag_pkg::item_t               item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [stcag_pkg::SRC_W-1:0]    src_element_offset_o,
  output logic [stcag_pkg::SRCB_W-1:0]   src_byte_offset_o,
  output logic [stcag_pkg::DSTB_W-1:0]   dst_byte_offset_o,
  output logic                           index_invalid_o
);

  localparam int unsigned D1 = stcag_pkg::IDX_W;
  localparam int unsigned D2 = stcag_pkg::Q2_W;
  localparam int unsigned SW = stcag_pkg::SIZE_W;

  logic adv;
  assign adv   = !(out_valid_o && out_stall_i);
  assign pop_o = q_valid_i && adv;

  // first divider: index / dim2 size
  logic                           d1_v_q    [0:D1];
  logic [SW-1:0]                  d1_r_q    [0:D1];
  logic [stcag_pkg::IDX_W-1:0]    d1_n_q    [0:D1];
  logic                           d1_inv_q  [0:D1];
  logic [stcag_pkg::DSTB_W-1:0]   d1_dstb_q [0:D1];

  assign d1_v_q[0]    = pop_o;
  assign d1_r_q[0]    = '0;
  assign d1_n_q[0]    = item_i.idx;
  assign d1_inv_q[0]  = item_i.invalid;
  assign d1_dstb_q[0] = item_i.dst_byte;

  for (genvar k = 0; k < D1; k++) begin : g_d1
    logic [SW:0] t;
    logic        ge;
    assign t  = {d1_r_q[k], d1_n_q[k][stcag_pkg::IDX_W-1]};
    assign ge = (t >= {1'b0, cfg_i.size[2]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        d1_v_q[k+1] <= d1_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_r_q[k+1]    <= ge ? SW'(t - {1'b0, cfg_i.size[2]}) : t[SW-1:0];
        d1_n_q[k+1]    <= {d1_n_q[k][stcag_pkg::IDX_W-2:0], ge};
        d1_inv_q[k+1]  <= d1_inv_q[k];
        d1_dstb_q[k+1] <= d1_dstb_q[k];
      end
    end
  end

  // second divider: quotient / dim1 size (quotient below 2^32 when valid)
  logic                           d2_v_q    [0:D2];
  logic [SW-1:0]                  d2_r_q    [0:D2];
  logic [D2-1:0]                  d2_n_q    [0:D2];
  logic [SW-1:0]                  d2_c2_q   [0:D2];
  logic                           d2_inv_q  [0:D2];
  logic [stcag_pkg::DSTB_W-1:0]   d2_dstb_q [0:D2];

  assign d2_v_q[0]    = d1_v_q[D1];
  assign d2_r_q[0]    = '0;
  assign d2_n_q[0]    = d1_n_q[D1][D2-1:0];
  assign d2_c2_q[0]   = d1_r_q[D1];
  assign d2_inv_q[0]  = d1_inv_q[D1];
  assign d2_dstb_q[0] = d1_dstb_q[D1];

  for (genvar k = 0; k < D2; k++) begin : g_d2
    logic [SW:0] t;
    logic        ge;
    assign t  = {d2_r_q[k], d2_n_q[k][D2-1]};
    assign ge = (t >= {1'b0, cfg_i.size[1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        d2_v_q[k+1] <= d2_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_r_q[k+1]    <= ge ? SW'(t - {1'b0, cfg_i.size[1]}) : t[SW-1:0];
        d2_n_q[k+1]    <= {d2_n_q[k][D2-2:0], ge};
        d2_c2_q[k+1]   <= d2_c2_q[k];
        d2_inv_q[k+1]  <= d2_inv_q[k];
        d2_dstb_q[k+1] <= d2_dstb_q[k];
      end
    end
  end

  // multiply, sum, scale
  logic                          mv_q, sv_q, ov_q;
  logic [stcag_pkg::MUL_W-1:0]   m0_q, m1_q, m2_q;
  logic                          m_inv_q, s_inv_q;
  logic [stcag_pkg::DSTB_W-1:0]  m_dstb_q, s_dstb_q;
  logic [stcag_pkg::SRC_W-1:0]   src_q, sum;
  logic [stcag_pkg::SRC_W+stcag_pkg::EB_W-1:0] srcb_full;

  assign sum = stcag_pkg::SRC_W'(m0_q) + stcag_pkg::SRC_W'(m1_q)
             + stcag_pkg::SRC_W'(m2_q) + stcag_pkg::SRC_W'(cfg_i.base);
  assign srcb_full = src_q * cfg_i.eb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      mv_q <= d2_v_q[D2];
      sv_q <= mv_q;
      ov_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0_q     <= d2_n_q[D2][SW-1:0] * cfg_i.stride[0];
      m1_q     <= d2_r_q[D2] * cfg_i.stride[1];
      m2_q     <= d2_c2_q[D2] * cfg_i.stride[2];
      m_inv_q  <= d2_inv_q[D2];
      m_dstb_q <= d2_dstb_q[D2];
      src_q    <= m_inv_q ? '0 : sum;
      s_inv_q  <= m_inv_q;
      s_dstb_q <= m_dstb_q;
      src_element_offset_o <= src_q;
      src_byte_offset_o    <= s_inv_q ? '0 : srcb_full[stcag_pkg::SRCB_W-1:0];
      dst_byte_offset_o    <= s_dstb_q;
      index_invalid_o      <= s_inv_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

[rtl/strided_to_contiguous_addr_gen_unit.sv]
// ----------------------------------------------------------------------------
// strided_to_contiguous_addr_gen_unit
// Gather address generator: destination index to source element/byte offset.
// ----------------------------------------------------------------------------
// Use:
//  - Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//    Ready is always high; write only while the unit is empty.
//  - Input: dest_index_i with in_valid_i; in_stall_o holds the item off.
//  - Output: four result fields with out_valid_o; out_stall_i holds them.
//  - Throughput: one item per cycle, sustained, when the output is not
//    stalled. Every item gives exactly one result, in order.
//  - Path: the accepting edge loads the first front stage; then come 1 more
//    front stage, the queue, 48 + 32 stages of the bit-per-stage restoring
//    dividers that split the index by dim2 and dim1 sizes, then multiply,
//    sum and scale.
//  - A stalled output freezes the back pipeline; the front and its
//    two-entry queue keep taking items until the queue and both front stages are full.
//  - Reset empties all pipelines and restores register defaults:
//    sizes 1, strides 0/0/1, base 0, 4 bytes per element.
// ----------------------------------------------------------------------------
module strided_to_contiguous_addr_gen_unit #(
  parameter int unsigned MAX_DIMS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stcag_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stcag_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [stcag_pkg::IDX_W-1:0]        dest_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [stcag_pkg::SRC_W-1:0]        src_element_offset_o,
  output logic [stcag_pkg::SRCB_W-1:0]       src_byte_offset_o,
  output logic [stcag_pkg::DSTB_W-1:0]       dst_byte_offset_o,
  output logic                               index_invalid_o
);

  // configuration registers
  logic [stcag_pkg::NDIM-1:0][stcag_pkg::SIZE_W-1:0]   size_q;
  logic [stcag_pkg::NDIM-1:0][stcag_pkg::STRIDE_W-1:0] stride_q;
  logic [stcag_pkg::STRIDE_W-1:0]                      base_q;
  logic [stcag_pkg::EB_W-1:0]                          eb_q;
  stcag_pkg::cfg_t                                     cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0]   <= 16'd1;
      size_q[1]   <= 16'd1;
      size_q[2]   <= 16'd1;
      stride_q[0] <= 32'd0;
      stride_q[1] <= 32'd0;
      stride_q[2] <= 32'd1;
      base_q      <= 32'd0;
      eb_q        <= 4'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        stcag_pkg::REG_DIM0_SIZE:   size_q[0]   <= cfg_data_i[stcag_pkg::SIZE_W-1:0];
        stcag_pkg::REG_DIM1_SIZE:   size_q[1]   <= cfg_data_i[stcag_pkg::SIZE_W-1:0];
        stcag_pkg::REG_DIM2_SIZE:   size_q[2]   <= cfg_data_i[stcag_pkg::SIZE_W-1:0];
        stcag_pkg::REG_DIM0_STRIDE: stride_q[0] <= cfg_data_i;
        stcag_pkg::REG_DIM1_STRIDE: stride_q[1] <= cfg_data_i;
        stcag_pkg::REG_DIM2_STRIDE: stride_q[2] <= cfg_data_i;
        stcag_pkg::REG_BASE_OFFSET: base_q      <= cfg_data_i;
        stcag_pkg::REG_ELEM_BYTES:  eb_q        <= cfg_data_i[stcag_pkg::EB_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions at or above MAX_DIMS behave as size 1, stride 0
  always_comb begin
    for (int d = 0; d < stcag_pkg::NDIM; d++) begin
      if (d < MAX_DIMS) begin
        cfg.size[d]   = size_q[d];
        cfg.stride[d] = stride_q[d];
      end else begin
        cfg.size[d]   = 16'd1;
        cfg.stride[d] = 32'd0;
      end
    end
    cfg.base = base_q;
    cfg.eb   = eb_q;
  end

  logic             push, full, q_valid, pop;
  stcag_pkg::item_t f_item, q_item;

  stcag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dest_index_i (dest_index_i),
    .push_o       (push),
    .item_o       (f_item),
    .full_i       (full)
  );

  stcag_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  stcag_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .q_valid_i            (q_valid),
    .item_i               (q_item),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .src_element_offset_o (src_element_offset_o),
    .src_byte_offset_o    (src_byte_offset_o),
    .dst_byte_offset_o    (dst_byte_offset_o),
    .index_invalid_o      (index_invalid_o)
  );

endmodule
